// File: rtl/core/impulse_collision_response_2d_defines.svh
// ----------------------------------------------------------------------------
// Impulse collision response assertion macros
// Shared property macros, sampled on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef IMPULSE_COLLISION_RESPONSE_2D_DEFINES_SVH
`define IMPULSE_COLLISION_RESPONSE_2D_DEFINES_SVH

// cons must hold in every cycle in which ante holds
`define ICR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// cond must never hold
`define ICR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// File: rtl/core/icr_pkg.sv
// ----------------------------------------------------------------------------
// Impulse collision response package
// Widths, lane codes and shared types of the collision datapath.
// ----------------------------------------------------------------------------
package icr_pkg;

  localparam int unsigned VEL_W      = 16;
  localparam int unsigned NRM_W      = 16;
  localparam int unsigned MASS_W     = 16;
  localparam int unsigned RV_W       = VEL_W + 1;
  localparam int unsigned PROD_W     = RV_W + NRM_W;
  localparam int unsigned DOT_W      = PROD_W + 1;
  localparam int unsigned TWOD_W     = DOT_W;
  localparam int unsigned HALF_W     = TWOD_W / 2;
  localparam int unsigned MAG_W      = NRM_W;
  localparam int unsigned MULT_W     = MASS_W;
  localparam int unsigned W_W        = MAG_W + MULT_W;
  localparam int unsigned PP_W       = W_W + (TWOD_W - HALF_W);
  localparam int unsigned NUM_W      = W_W + TWOD_W;
  localparam int unsigned FRAC_SHIFT = 28;
  localparam int unsigned RND_SHIFT  = FRAC_SHIFT - 1;
  localparam int unsigned REM_W      = NUM_W - RND_SHIFT;
  localparam int unsigned SUM_W      = MASS_W + 1;
  localparam int unsigned DEN_W      = SUM_W + 1;
  localparam int unsigned QUO_W      = 21;
  localparam int unsigned RES_W      = QUO_W + 2;
  localparam int unsigned NUM_LANES  = 4;

  localparam int unsigned DIV_STEPS_DEF = 1;

  // velocity component lanes
  localparam int unsigned LANE_AX = 0;
  localparam int unsigned LANE_AY = 1;
  localparam int unsigned LANE_BX = 2;
  localparam int unsigned LANE_BY = 3;

  typedef logic [NUM_LANES-1:0][VEL_W-1:0] icr_vel_lanes_t;
  typedef logic [NUM_LANES-1:0][REM_W-1:0] icr_rem_lanes_t;
  typedef logic [NUM_LANES-1:0][QUO_W-1:0] icr_quo_lanes_t;

  typedef struct packed {
    icr_vel_lanes_t vel;
    logic           neg_x;
    logic           neg_y;
    logic           resolved;
    logic           both_static;
  } icr_side_t;

endpackage

// File: rtl/core/icr_intf.sv
// ----------------------------------------------------------------------------
// Impulse collision response channels
// Valid/ready channels for collision words in and response words out.
// ----------------------------------------------------------------------------
interface icr_in_if;
  import icr_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] vel_a_x;
  logic signed [VEL_W-1:0] vel_a_y;
  logic signed [VEL_W-1:0] vel_b_x;
  logic signed [VEL_W-1:0] vel_b_y;
  logic signed [NRM_W-1:0] normal_x;
  logic signed [NRM_W-1:0] normal_y;
  logic [MASS_W-1:0]       mass_a;
  logic [MASS_W-1:0]       mass_b;
  logic                    static_a;
  logic                    static_b;

  modport source (
    output valid, vel_a_x, vel_a_y, vel_b_x, vel_b_y, normal_x, normal_y,
    output mass_a, mass_b, static_a, static_b,
    input  ready
  );

  modport sink (
    input  valid, vel_a_x, vel_a_y, vel_b_x, vel_b_y, normal_x, normal_y,
    input  mass_a, mass_b, static_a, static_b,
    output ready
  );
endinterface

interface icr_out_if;
  import icr_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] new_vel_a_x;
  logic signed [VEL_W-1:0] new_vel_a_y;
  logic signed [VEL_W-1:0] new_vel_b_x;
  logic signed [VEL_W-1:0] new_vel_b_y;
  logic                    resolved;
  logic                    both_static;
  logic                    saturated;

  modport source (
    output valid, new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y,
    output resolved, both_static, saturated,
    input  ready
  );

  modport sink (
    input  valid, new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y,
    input  resolved, both_static, saturated,
    output ready
  );
endinterface

// File: rtl/core/icr_front.sv
// ----------------------------------------------------------------------------
// Impulse collision response front end
// Four stages: relative velocity dot normal and mass weights, impulse
// magnitude, split wide products, rounding offset and dividend assembly.
// ----------------------------------------------------------------------------
module icr_front (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  icr_in_if.sink                                    in_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output icr_pkg::icr_rem_lanes_t                   dvd_o,
  output logic [icr_pkg::DEN_W-1:0]                 den_o,
  output icr_pkg::icr_side_t                        side_o
);
  import icr_pkg::*;

  typedef logic [NUM_LANES-1:0][W_W-1:0]  w_lanes_t;
  typedef logic [NUM_LANES-1:0][PP_W-1:0] pp_lanes_t;

  logic rdy1, rdy2, rdy3, rdy4;
  logic v1_q, v2_q, v3_q, v4_q;

  // stage 1
  logic signed [RV_W-1:0]   rv_x, rv_y;
  logic [MAG_W-1:0]         mag_x, mag_y;
  logic [SUM_W-1:0]         sum;
  logic [MULT_W-1:0]        mult_a, mult_b;
  logic signed [PROD_W-1:0] prod_x_d, prod_y_d, prod_x_q, prod_y_q;
  w_lanes_t                 w1_d, w1_q;
  logic [SUM_W-1:0]         s1_d, s1_q;
  icr_side_t                side1_d, side1_q;

  // stage 2
  logic signed [DOT_W-1:0]  dot;
  logic                     approach;
  logic [TWOD_W-1:0]        two_d_d, two_d_q;
  w_lanes_t                 w2_q;
  logic [SUM_W-1:0]         s2_q;
  icr_side_t                side2_d, side2_q;

  // stage 3
  pp_lanes_t                pl_d, ph_d, pl_q, ph_q;
  logic [SUM_W-1:0]         s3_q;
  icr_side_t                side3_q;

  // stage 4
  icr_rem_lanes_t           dvd_d, dvd_q;
  logic [DEN_W-1:0]         den_q;
  icr_side_t                side4_q;

  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_i.ready = rdy1;

  always_comb begin
    logic dyn_both;
    logic sum_nz;
    rv_x     = RV_W'(in_i.vel_b_x) - RV_W'(in_i.vel_a_x);
    rv_y     = RV_W'(in_i.vel_b_y) - RV_W'(in_i.vel_a_y);
    prod_x_d = PROD_W'(rv_x) * PROD_W'(in_i.normal_x);
    prod_y_d = PROD_W'(rv_y) * PROD_W'(in_i.normal_y);
    mag_x    = in_i.normal_x[NRM_W-1] ? MAG_W'(-in_i.normal_x) : MAG_W'(in_i.normal_x);
    mag_y    = in_i.normal_y[NRM_W-1] ? MAG_W'(-in_i.normal_y) : MAG_W'(in_i.normal_y);
    sum      = SUM_W'(in_i.mass_a) + SUM_W'(in_i.mass_b);
    sum_nz   = (sum != '0);
    dyn_both = !in_i.static_a && !in_i.static_b;
    // weight numerators over a shared denominator; a lone dynamic body takes it all
    if (dyn_both) begin
      mult_a = sum_nz ? in_i.mass_b : '0;
      mult_b = sum_nz ? in_i.mass_a : '0;
      s1_d   = sum_nz ? sum : SUM_W'(1);
    end else begin
      mult_a = !in_i.static_a ? MULT_W'(1) : '0;
      mult_b = !in_i.static_b ? MULT_W'(1) : '0;
      s1_d   = SUM_W'(1);
    end
    w1_d[LANE_AX] = W_W'(mag_x) * W_W'(mult_a);
    w1_d[LANE_AY] = W_W'(mag_y) * W_W'(mult_a);
    w1_d[LANE_BX] = W_W'(mag_x) * W_W'(mult_b);
    w1_d[LANE_BY] = W_W'(mag_y) * W_W'(mult_b);
    side1_d.vel[LANE_AX] = in_i.vel_a_x;
    side1_d.vel[LANE_AY] = in_i.vel_a_y;
    side1_d.vel[LANE_BX] = in_i.vel_b_x;
    side1_d.vel[LANE_BY] = in_i.vel_b_y;
    side1_d.neg_x        = in_i.normal_x[NRM_W-1];
    side1_d.neg_y        = in_i.normal_y[NRM_W-1];
    side1_d.resolved     = 1'b0;
    // both static flag before the approach test
    side1_d.both_static  = in_i.static_a && in_i.static_b;
  end

  always_comb begin
    dot      = DOT_W'(prod_x_q) + DOT_W'(prod_y_q);
    approach = !dot[DOT_W-1];
    two_d_d  = approach ? {dot[DOT_W-2:0], 1'b0} : '0;
    side2_d             = side1_q;
    side2_d.resolved    = approach;
    side2_d.both_static = approach && side1_q.both_static;
  end

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      pl_d[l] = PP_W'(w2_q[l]) * PP_W'(two_d_q[HALF_W-1:0]);
      ph_d[l] = PP_W'(w2_q[l]) * PP_W'(two_d_q[TWOD_W-1:HALF_W]);
    end
  end

  // (num + s * 2^27) >> 27, so the quotient by 2s rounds half away from zero
  always_comb begin
    logic [NUM_W-1:0] num;
    num = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      num = (NUM_W'(ph_q[l]) << HALF_W) + NUM_W'(pl_q[l]) + (NUM_W'(s3_q) << RND_SHIFT);
      dvd_d[l] = num[NUM_W-1:RND_SHIFT];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_i.valid) begin
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
      w1_q     <= w1_d;
      s1_q     <= s1_d;
      side1_q  <= side1_d;
    end
    if (rdy2 && v1_q) begin
      two_d_q <= two_d_d;
      w2_q    <= w1_q;
      s2_q    <= s1_q;
      side2_q <= side2_d;
    end
    if (rdy3 && v2_q) begin
      pl_q    <= pl_d;
      ph_q    <= ph_d;
      s3_q    <= s2_q;
      side3_q <= side2_q;
    end
    if (rdy4 && v3_q) begin
      dvd_q   <= dvd_d;
      den_q   <= {s3_q, 1'b0};
      side4_q <= side3_q;
    end
  end

  assign out_valid_o = v4_q;
  assign dvd_o       = dvd_q;
  assign den_o       = den_q;
  assign side_o      = side4_q;

endmodule

// File: rtl/core/icr_div.sv
// ----------------------------------------------------------------------------
// Impulse collision response divider
// Pipelined restoring divider, four lanes over one shared divisor,
// StepsPerStage quotient bits per stage.
// ----------------------------------------------------------------------------
module icr_div #(
  parameter int unsigned StepsPerStage = icr_pkg::DIV_STEPS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  icr_pkg::icr_rem_lanes_t   dvd_i,
  input  logic [icr_pkg::DEN_W-1:0] den_i,
  input  icr_pkg::icr_side_t        side_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output icr_pkg::icr_quo_lanes_t   quo_o,
  output icr_pkg::icr_side_t        side_o
);
  import icr_pkg::*;

  localparam int unsigned NumStages = (QUO_W + StepsPerStage - 1) / StepsPerStage;

  logic [NumStages-1:0] valid_q;
  logic [NumStages:0]   rdy;
  icr_rem_lanes_t       rem_q  [NumStages];
  icr_quo_lanes_t       quo_q  [NumStages];
  logic [DEN_W-1:0]     den_q  [NumStages];
  icr_side_t            side_q [NumStages];

  assign rdy[NumStages] = out_ready_i;

  for (genvar k = 0; k < NumStages; k++) begin : g_stage
    logic             valid_in;
    icr_rem_lanes_t   rem_in, rem_d;
    icr_quo_lanes_t   quo_in, quo_d;
    logic [DEN_W-1:0] den_in;
    icr_side_t        side_in;

    if (k == 0) begin : g_head
      assign valid_in = in_valid_i;
      assign rem_in   = dvd_i;
      assign quo_in   = '0;
      assign den_in   = den_i;
      assign side_in  = side_i;
    end else begin : g_body
      assign valid_in = valid_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign quo_in   = quo_q[k-1];
      assign den_in   = den_q[k-1];
      assign side_in  = side_q[k-1];
    end

    assign rdy[k] = !valid_q[k] || rdy[k+1];

    always_comb begin
      logic [REM_W-1:0] dsh;
      int               bit_pos;
      rem_d   = rem_in;
      quo_d   = quo_in;
      dsh     = '0;
      bit_pos = 0;
      for (int j = 0; j < int'(StepsPerStage); j++) begin
        bit_pos = int'(QUO_W) - 1 - int'(k * StepsPerStage) - j;
        if (bit_pos >= 0) begin
          dsh = REM_W'(den_in) << bit_pos;
          for (int l = 0; l < NUM_LANES; l++) begin
            if (rem_d[l] >= dsh) begin
              rem_d[l] = rem_d[l] - dsh;
              quo_d[l] = {quo_d[l][QUO_W-2:0], 1'b1};
            end else begin
              quo_d[l] = {quo_d[l][QUO_W-2:0], 1'b0};
            end
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && valid_in) begin
        rem_q[k]  <= rem_d;
        quo_q[k]  <= quo_d;
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[NumStages-1];
  assign quo_o       = quo_q[NumStages-1];
  assign side_o      = side_q[NumStages-1];

endmodule

// File: rtl/core/icr_back.sv
// ----------------------------------------------------------------------------
// Impulse collision response back end
// Applies the signed velocity changes, clamps to Q8.8 and holds the
// response word in the output register.
// ----------------------------------------------------------------------------
module icr_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  icr_pkg::icr_quo_lanes_t quo_i,
  input  icr_pkg::icr_side_t      side_i,
  icr_out_if.source               out_o
);
  import icr_pkg::*;

  localparam logic signed [RES_W-1:0] VelMax = RES_W'(2 ** (VEL_W - 1) - 1);
  localparam logic signed [RES_W-1:0] VelMin = ~VelMax;

  logic           rdy;
  logic           valid_q;
  icr_vel_lanes_t vel_d, vel_q;
  logic           sat_d, sat_q;
  logic           resolved_q;
  logic           both_static_q;

  assign rdy        = !valid_q || out_o.ready;
  assign in_ready_o = rdy;

  always_comb begin
    logic signed [RES_W-1:0] vel_ext;
    logic signed [RES_W-1:0] quo_ext;
    logic signed [RES_W-1:0] res;
    logic                    neg;
    logic                    body_a;
    vel_d   = '0;
    sat_d   = 1'b0;
    vel_ext = '0;
    quo_ext = '0;
    res     = '0;
    neg     = 1'b0;
    body_a  = 1'b0;
    for (int l = 0; l < NUM_LANES; l++) begin
      body_a  = (l == LANE_AX) || (l == LANE_AY);
      neg     = ((l == LANE_AX) || (l == LANE_BX)) ? side_i.neg_x : side_i.neg_y;
      vel_ext = RES_W'($signed(side_i.vel[l]));
      quo_ext = $signed(RES_W'(quo_i[l]));
      // a gains the change along n, b loses it
      res     = (body_a ^ neg) ? vel_ext + quo_ext : vel_ext - quo_ext;
      if (res > VelMax) begin
        vel_d[l] = VelMax[VEL_W-1:0];
        sat_d    = 1'b1;
      end else if (res < VelMin) begin
        vel_d[l] = VelMin[VEL_W-1:0];
        sat_d    = 1'b1;
      end else begin
        vel_d[l] = res[VEL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (rdy) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && in_valid_i) begin
      vel_q         <= vel_d;
      sat_q         <= sat_d;
      resolved_q    <= side_i.resolved;
      both_static_q <= side_i.both_static;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.new_vel_a_x = vel_q[LANE_AX];
  assign out_o.new_vel_a_y = vel_q[LANE_AY];
  assign out_o.new_vel_b_x = vel_q[LANE_BX];
  assign out_o.new_vel_b_y = vel_q[LANE_BY];
  assign out_o.resolved    = resolved_q;
  assign out_o.both_static = both_static_q;
  assign out_o.saturated   = sat_q;

endmodule

// File: rtl/core/impulse_collision_response_2d.sv
// ----------------------------------------------------------------------------
// Impulse collision response 2D
// Resolves one two-body contact per word with restitution 1 and returns the
// updated Q8.8 velocities. A new word is taken every cycle while the output
// is not stalled; after it is accepted, the word passes the front-end stages,
// the divider stages and the output register. Most of the pipeline is the
// 21-bit restoring division of each velocity change by the summed masses,
// done for all four velocity components side by side. A stalled output only
// backs up the stages that hold words; empty stages keep filling.
// ----------------------------------------------------------------------------
`include "impulse_collision_response_2d_defines.svh"

module impulse_collision_response_2d #(
  parameter int unsigned DivStepsPerStage = icr_pkg::DIV_STEPS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  icr_in_if.sink     in_i,
  icr_out_if.source  out_o
);
  import icr_pkg::*;

  logic             fe_valid, fe_ready;
  icr_rem_lanes_t   fe_dvd;
  logic [DEN_W-1:0] fe_den;
  icr_side_t        fe_side;

  logic             dv_valid, dv_ready;
  icr_quo_lanes_t   dv_quo;
  icr_side_t        dv_side;

  icr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_valid_o (fe_valid),
    .out_ready_i (fe_ready),
    .dvd_o       (fe_dvd),
    .den_o       (fe_den),
    .side_o      (fe_side)
  );

  icr_div #(
    .StepsPerStage (DivStepsPerStage)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fe_valid),
    .in_ready_o  (fe_ready),
    .dvd_i       (fe_dvd),
    .den_i       (fe_den),
    .side_i      (fe_side),
    .out_valid_o (dv_valid),
    .out_ready_i (dv_ready),
    .quo_o       (dv_quo),
    .side_o      (dv_side)
  );

  icr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (dv_valid),
    .in_ready_o (dv_ready),
    .quo_i      (dv_quo),
    .side_i     (dv_side),
    .out_o      (out_o)
  );

  `ICR_ASSERT_IMP(a_empty_out_ready, !out_o.valid, in_i.ready, "input stalled with empty output")
  `ICR_ASSERT_NEVER(a_sep_flags, out_o.valid && !out_o.resolved && (out_o.both_static || out_o.saturated), "flags set on separating contact")
  `ICR_ASSERT_IMP(a_static_no_clamp, out_o.valid && out_o.both_static, !out_o.saturated, "clamp on pass-through")

endmodule
